FILE: hw/rtl/sle_pkg.sv
// shared types and constants for the sequential list engine
package sle_pkg;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 8;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 4;
   localparam int LEN_W    = 5;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_LOCATE = 3'd2,
      CMD_GET    = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_RANGE    = 2'd2,
      STS_NOTFOUND = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_INS_WR = 2'd2,
      ST_RESP   = 2'd3
   } state_type;

endpackage

FILE: hw/rtl/sle_req_if.sv
// command channel interface of the sequential list engine
interface sle_req_if;
   logic                              valid;
   logic                              ready;
   logic [sle_pkg::CMD_W-1:0]         command;
   logic [sle_pkg::POS_W-1:0]         position;
   logic signed [sle_pkg::VAL_W-1:0]  value;

   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

FILE: hw/rtl/sle_rsp_if.sv
// result channel interface of the sequential list engine
interface sle_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sle_pkg::STATUS_W-1:0]        status;
   logic signed [sle_pkg::VAL_W-1:0]    item_value;
   logic [sle_pkg::FOUND_W-1:0]         found_index;
   logic [sle_pkg::LEN_W-1:0]           list_length;

   modport source (output valid, status, item_value, found_index, list_length, input ready);
   modport sink   (input valid, status, item_value, found_index, list_length, output ready);
endinterface

FILE: hw/rtl/sequential_list_engine.sv
// Sequential list engine: ordered list of signed 32-bit values in one memory
//
// Commands arrive as words on req_bus (valid/ready); each gives exactly one
// result word on rsp_bus. Commands: insert at a position, delete at a
// position (returns the removed value), locate the first index of a value,
// get the entry at a position, and clear.
// One command is worked on at a time. The entries live in a single-port-write,
// single-port-read memory with a registered read; insert, delete and
// locate walk the affected entries one per cycle through that memory. Get
// reads one entry; an insert at the tail skips the walk and only writes the
// new value, and clear and rejected commands go straight to the result. The
// longest commands are a delete or locate over a full list and an insert at
// the head of a list one short of full. The result word appears in the same
// cycle as the sequencer returns to idle; a new command is taken as soon as
// the sequencer is idle, even while that result still waits in the output
// register.
// When the receiver stalls, the next result waits in the sequencer until the
// output register is taken.
// Reset empties the list (length zero); the memory contents are not cleared
// since no entry at or beyond the length is ever read.
module sequential_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   sle_req_if.sink   req_bus,
   sle_rsp_if.source rsp_bus
);
   import sle_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // entry memory
   logic [VAL_W-1:0] mem [CAPACITY];
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [VAL_W-1:0] rd_data_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [VAL_W-1:0] wr_data;

   // control state
   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] end_ff, end_in;
   logic          issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [AW-1:0]      pos_ff, pos_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   status_type         status_ff, status_in;
   logic [VAL_W-1:0]   item_ff, item_in;
   logic [FOUND_W-1:0] found_ff, found_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]    rsp_item_ff, rsp_item_in;
   logic [FOUND_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   logic          req_fire;
   cmd_type       req_cmd;
   logic [POS_W-1:0] count_wide;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_cmd       = cmd_type'(req_bus.command);
   assign count_wide    = POS_W'(count_ff);

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.item_value  = rsp_item_ff;
   assign rsp_bus.found_index = rsp_found_ff;
   assign rsp_bus.list_length = rsp_len_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // sequencer next state and memory control
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      end_in        = end_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      item_in       = item_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_len_in    = rsp_len_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_cmd;
               pos_in    = AW'(req_bus.position);
               val_in    = req_bus.value;
               status_in = STS_OK;
               item_in   = '0;
               found_in  = '0;
               state_in  = ST_RESP;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_in = STS_FULL;
                     end else if (req_bus.position > count_wide) begin
                        status_in = STS_RANGE;
                     end else if (req_bus.position == count_wide) begin
                        state_in = ST_INS_WR;
                     end else begin
                        cur_in   = AW'(count_ff - CW'(1));
                        end_in   = AW'(req_bus.position);
                        issue_in = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_DELETE, CMD_GET: begin
                     if (req_bus.position >= count_wide) begin
                        status_in = STS_RANGE;
                     end else begin
                        cur_in   = AW'(req_bus.position);
                        end_in   = (req_cmd == CMD_GET) ? AW'(req_bus.position)
                                                        : AW'(count_ff - CW'(1));
                        issue_in = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_LOCATE: begin
                     status_in = STS_NOTFOUND;
                     if (count_ff != '0) begin
                        cur_in   = '0;
                        end_in   = AW'(count_ff - CW'(1));
                        issue_in = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue the next read of the walk
            if (issue_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cur_ff;
               if (cur_ff == end_ff) begin
                  issue_in = 1'b0;
               end else if (cmd_ff == CMD_INSERT) begin
                  cur_in = cur_ff - AW'(1);
               end else begin
                  cur_in = cur_ff + AW'(1);
               end
            end
            // handle the word read in the previous cycle
            if (pend_ff) begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = pend_addr_ff + AW'(1);
                  end
                  CMD_DELETE: begin
                     if (pend_addr_ff == pos_ff) begin
                        item_in = rd_data_ff;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pend_addr_ff - AW'(1);
                     end
                  end
                  CMD_GET: begin
                     item_in = rd_data_ff;
                  end
                  default: begin
                     // locate: stop at the first match
                     if (rd_data_ff == val_ff) begin
                        status_in = STS_OK;
                        found_in  = FOUND_W'(pend_addr_ff);
                        issue_in  = 1'b0;
                        pend_in   = 1'b0;
                        state_in  = ST_RESP;
                     end
                  end
               endcase
               // walk finished
               if (!issue_ff) begin
                  if (cmd_ff == CMD_INSERT) begin
                     state_in = ST_INS_WR;
                  end else begin
                     state_in = ST_RESP;
                     if (cmd_ff == CMD_DELETE) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end
            end
         end

         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = val_ff;
            count_in = count_ff + CW'(1);
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_item_in   = item_ff;
               rsp_found_in  = found_ff;
               rsp_len_in    = LEN_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cur_ff        <= cur_in;
      end_ff        <= end_in;
      pend_addr_ff  <= pend_addr_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      item_ff       <= item_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // length never exceeds the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length above capacity");

   // a walk always has a read in flight or still to issue
   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (issue_ff || pend_ff))
      else $error("walk stalled with nothing pending");

   // the final insert write grows the list by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS_WR |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

endmodule

FILE: tb/sv/sequential_list_engine_tb.sv
// self-checking testbench for the sequential list engine
module sequential_list_engine_tb;
   import sle_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 560;
   localparam int CMD_TOP      = (1 << CMD_W) - 1;

   typedef struct {
      status_type              status;
      logic signed [VAL_W-1:0] item_value;
      logic [FOUND_W-1:0]      found_index;
      logic [LEN_W-1:0]        list_length;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sle_req_if req_if();
   sle_rsp_if rsp_if();

   sequential_list_engine #(.CAPACITY(CAPACITY)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always #5 clock = ~clock;

   // shadow copy of the list, updated on every accepted command word
   logic signed [VAL_W-1:0] shadow_list [CAPACITY];
   int unsigned             shadow_length = 0;
   list_result_type         pending_results [$];

   int error_count   = 0;
   int word_count    = 0;
   int result_count  = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles   = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   // apply one command to the shadow list and return the result it should give
   function automatic list_result_type apply_list_command(logic [CMD_W-1:0] cmd,
         logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
      list_result_type r;
      r.status      = STS_OK;
      r.item_value  = '0;
      r.found_index = '0;
      case (cmd)
         CMD_INSERT: begin
            // full check wins over the position check
            if (shadow_length >= CAPACITY) begin
               r.status = STS_FULL;
            end else if (pos > shadow_length) begin
               r.status = STS_RANGE;
            end else begin
               for (int i = shadow_length; i > pos; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = val;
               shadow_length++;
            end
         end
         CMD_DELETE: begin
            if (pos >= shadow_length) begin
               r.status = STS_RANGE;
            end else begin
               r.item_value = shadow_list[pos];
               for (int i = pos; i + 1 < shadow_length; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_length--;
            end
         end
         CMD_LOCATE: begin
            // first match only
            r.status = STS_NOTFOUND;
            for (int i = 0; i < shadow_length; i++) begin
               if (r.status != STS_OK && shadow_list[i] == val) begin
                  r.status      = STS_OK;
                  r.found_index = FOUND_W'(i);
               end
            end
         end
         CMD_GET: begin
            if (pos >= shadow_length)
               r.status = STS_RANGE;
            else
               r.item_value = shadow_list[pos];
         end
         CMD_CLEAR: begin
            shadow_length = 0;
         end
         default: begin
         end
      endcase
      r.list_length = LEN_W'(shadow_length);
      return r;
   endfunction

   // command and result monitor, plus the stall watchdog
   always @(posedge clock) begin
      list_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            pending_results.push_back(apply_list_command(req_if.command, req_if.position,
                                                         req_if.value));
            word_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            status_seen[rsp_if.status]++;
            if (pending_results.size() == 0) begin
               $error("result word with no command outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  error_count++;
               end
               if (rsp_if.item_value !== want.item_value) begin
                  $error("item_value: expected %0d, got %0d", want.item_value,
                         rsp_if.item_value);
                  error_count++;
               end
               if (rsp_if.found_index !== want.found_index) begin
                  $error("found_index: expected %0d, got %0d", want.found_index,
                         rsp_if.found_index);
                  error_count++;
               end
               if (rsp_if.list_length !== want.list_length) begin
                  $error("list_length: expected %0d, got %0d", want.list_length,
                         rsp_if.list_length);
                  error_count++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("sequential_list_engine_tb: errors");
            $finish;
         end
      end
   end

   // result-side ready: random idling, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_if.ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_if.ready = ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // offer one command word and wait for it to be taken; returns at a falling edge
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                            logic signed [VAL_W-1:0] val);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.command  = cmd;
      req_if.position = pos;
      req_if.value    = val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait until every expected result has come back
   task automatic drain_results(int settle);
      req_if.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // well-formed list traffic with random content, some noise mixed in
   task automatic send_random_commands(int count);
      int ins_w;
      int del_w;
      int pick;
      int list_len;
      logic [CMD_W-1:0]        cmd;
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] val;
      for (int n = 0; n < count; n++) begin
         // batches lean toward growing, shrinking or a balanced mix
         if (n % 48 == 0) begin
            case ($urandom_range(2, 0))
               0:       begin ins_w = 55; del_w = 10; end
               1:       begin ins_w = 15; del_w = 45; end
               default: begin ins_w = 30; del_w = 20; end
            endcase
         end
         list_len = shadow_length;
         pick     = $urandom_range(99, 0);
         if (pick < ins_w)
            cmd = CMD_INSERT;
         else if (pick < ins_w + del_w)
            cmd = CMD_DELETE;
         else if (pick < 98)
            cmd = $urandom_range(1, 0) ? CMD_LOCATE : CMD_GET;
         else if (pick == 98)
            cmd = CMD_CLEAR;
         else
            cmd = CMD_W'($urandom_range(CMD_TOP, int'(CMD_CLEAR) + 1));

         // positions mostly in range, sometimes anywhere
         if ($urandom_range(9, 0) == 0)
            pos = POS_W'($urandom);
         else if (cmd == CMD_INSERT)
            pos = POS_W'($urandom_range(list_len, 0));
         else if (list_len == 0)
            pos = '0;
         else
            pos = POS_W'($urandom_range(list_len - 1, 0));

         // small values give duplicates for locate, extremes hit the sign bit
         case ($urandom_range(3, 0))
            0: val = VAL_W'($urandom_range(8, 0)) - 4;
            1: begin
               case ($urandom_range(3, 0))
                  0:       val = {1'b1, {(VAL_W-1){1'b0}}};
                  1:       val = {1'b0, {(VAL_W-1){1'b1}}};
                  2:       val = '1;
                  default: val = '0;
               endcase
            end
            default: val = $urandom;
         endcase
         if (cmd == CMD_LOCATE && list_len > 0 && $urandom_range(9, 0) < 6)
            val = shadow_list[$urandom_range(list_len - 1, 0)];

         send_word(cmd, pos, val);
      end
   endtask

   // empty-list errors, inserts at head, middle and tail, duplicates, odd codes
   task automatic test_directed_cases();
      send_word(CMD_GET,    '0, '0);
      send_word(CMD_DELETE, '0, '0);
      send_word(CMD_LOCATE, '0, '0);
      send_word(CMD_INSERT, 8'd1, 32'sd5);
      send_word(CMD_INSERT, '1, 32'sd5);
      send_word(CMD_INSERT, '0, 32'sh7fff_ffff);
      send_word(CMD_INSERT, '0, 32'sh8000_0000);
      send_word(CMD_INSERT, 8'd2, -32'sd1);
      send_word(CMD_INSERT, 8'd1, 32'sd0);
      send_word(CMD_INSERT, 8'd4, 32'sh8000_0000);
      send_word(CMD_LOCATE, '0, 32'sh8000_0000);
      send_word(CMD_LOCATE, '1, -32'sd1);
      send_word(CMD_LOCATE, '0, 32'sd12345);
      send_word(CMD_GET,    '0, '0);
      send_word(CMD_GET,    8'd4, '0);
      send_word(CMD_GET,    8'd5, '0);
      send_word(CMD_GET,    '1, '1);
      send_word(CMD_DELETE, 8'd2, '0);
      send_word(CMD_DELETE, 8'd3, '0);
      send_word(CMD_DELETE, '0, '0);
      send_word(CMD_DELETE, '1, '0);
      send_word(CMD_W'(int'(CMD_CLEAR) + 1), '1, '1);
      send_word(CMD_W'(CMD_TOP), 8'd1, 32'sd99);
      send_word(CMD_CLEAR,  '1, '1);
      send_word(CMD_GET,    '0, '0);
      drain_results(2);
   endtask

   // fill to capacity, poke the full list, then empty it from the head
   task automatic test_fill_to_capacity();
      send_word(CMD_CLEAR, '0, '0);
      repeat (CAPACITY) send_word(CMD_INSERT, POS_W'($urandom_range(shadow_length, 0)), $urandom);
      send_word(CMD_INSERT, '0, 32'sd7);
      send_word(CMD_INSERT, '1, 32'sd7);
      send_word(CMD_LOCATE, '0, shadow_list[CAPACITY-1]);
      send_word(CMD_GET,    POS_W'(CAPACITY - 1), '0);
      send_word(CMD_GET,    POS_W'(CAPACITY), '0);
      send_word(CMD_DELETE, POS_W'(CAPACITY - 1), '0);
      send_word(CMD_INSERT, POS_W'(CAPACITY - 1), $urandom);
      repeat (CAPACITY) send_word(CMD_DELETE, '0, '0);
      send_word(CMD_DELETE, '0, '0);
      drain_results(2);
   endtask

   // long receiver hold-off while commands keep coming, so the input stalls
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles   = 300;
      send_random_commands(12);
      drain_results(2);
   endtask

   // random traffic under three idling patterns
   task automatic test_random_traffic();
      send_idle_pct = 30;
      recv_idle_pct = 51;
      send_random_commands(PHASE_ITEMS);
      drain_results(2);
      send_idle_pct = 51;
      recv_idle_pct = 30;
      send_random_commands(PHASE_ITEMS);
      drain_results(2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_commands(PHASE_ITEMS);
      drain_results(2);
   endtask

   initial begin
      req_if.valid    = 1'b0;
      req_if.command  = CMD_INSERT;
      req_if.position = '0;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_fill_to_capacity();
      test_output_backpressure();
      test_random_traffic();
      drain_results(DRAIN_CYCLES);

      $display("covered %0d command words, %0d result words", word_count, result_count);
      $display("status ok/full/range/not-found: %0d/%0d/%0d/%0d", status_seen[STS_OK],
               status_seen[STS_FULL], status_seen[STS_RANGE], status_seen[STS_NOTFOUND]);
      if (error_count == 0) begin
         $display("sequential_list_engine_tb: clean");
      end else begin
         $display("sequential_list_engine_tb: errors");
      end
      $finish;
   end

endmodule
